@@ src/edf_pkg.sv @@
package edf_pkg;

  localparam int unsigned MaxLenDefault = 128;

  typedef enum logic [1:0] {
    MODE_FIRST  = 2'd0,
    MODE_SECOND = 2'd1,
    MODE_CMP    = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] character;
  } in_item_t;

  typedef struct packed {
    logic [7:0] distance;
    logic       is_match;
    logic       truncated;
  } out_item_t;

  // Command passed from the front to the back through the queue.
  typedef struct packed {
    logic       is_cmp;
    logic       second;
    logic [7:0] character;
  } cmd_t;

  localparam logic [0:0] REG_CASE_FOLD = 1'b0;

  function automatic logic [7:0] fold(input logic en, input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (en && c >= 8'd65 && c <= 8'd90) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage

@@ src/edf_front.sv @@
module edf_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  edf_pkg::in_item_t item,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output edf_pkg::cmd_t    cmd
);

  // Two-entry queue of classified commands; mode three is dropped here.
  edf_pkg::cmd_t q [2];
  logic          rd_ptr;
  logic          wr_ptr;
  logic [1:0]    count;
  logic          do_wr;
  logic          do_rd;
  logic          keep;

  assign full      = (count == 2'd2);
  assign keep      = (item.mode != edf_pkg::MODE_NONE);
  assign do_wr     = push && !full && keep;
  assign cmd_valid = (count != 2'd0);
  assign do_rd     = cmd_valid && cmd_ready;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      q[wr_ptr].is_cmp    <= (item.mode == edf_pkg::MODE_CMP);
      q[wr_ptr].second    <= (item.mode == edf_pkg::MODE_SECOND);
      q[wr_ptr].character <= item.character;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr <= !wr_ptr;
      if (do_rd) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !do_wr) else $error("queue written while full");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("queue count out of range");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (do_wr && !do_rd) |=> count == $past(count) + 2'd1) else $error("bad count step");

endmodule

@@ src/edf_back.sv @@
module edf_back #(
  parameter int unsigned MAX_LEN = edf_pkg::MaxLenDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              case_fold,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  edf_pkg::cmd_t     cmd,
  output logic              empty,
  input  logic              pop,
  output edf_pkg::out_item_t result
);

  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam logic [LW-1:0] LenMax = LW'(MAX_LEN);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_INIT = 6'b000010,
    S_ROWA = 6'b000100,
    S_ROWB = 6'b001000,
    S_CELL = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state;

  // String and cost-row memories.
  logic [7:0]    str_a [MAX_LEN];
  logic [7:0]    str_b [MAX_LEN];
  logic [7:0]    row   [MAX_LEN+1];
  logic [LW-1:0] len_a, len_b;
  logic [4:0]    seen;
  logic          ovf;

  logic [LW-1:0] i, j;
  logic [7:0]    a_ch, b_rd, up_rd;
  logic [7:0]    diag, left;
  logic          out_full;
  logic [7:0]    dist_r;

  logic [8:0] sub_c, del_c, ins_c, best;
  logic [7:0] tol;
  logic       fin_empty;
  logic       post;

  assign cmd_ready = (state == S_IDLE);
  assign empty     = !out_full;
  assign post      = (state == S_DONE) && (!out_full || pop);

  // Cell update of the distance sweep.
  always_comb begin
    sub_c = {1'b0, diag} + ((edf_pkg::fold(case_fold, a_ch) == edf_pkg::fold(case_fold, b_rd))
                            ? 9'd0 : 9'd1);
    del_c = {1'b0, up_rd} + 9'd1;
    ins_c = {1'b0, left} + 9'd1;
    best  = sub_c;
    if (del_c < best) best = del_c;
    if (ins_c < best) best = ins_c;
  end

  always_comb begin
    tol = 8'd2;
    if (seen > 5'd5)  tol = 8'd3;
    if (seen > 5'd10) tol = 8'd4;
    if (seen > 5'd15) tol = 8'd5;
  end

  assign fin_empty = (len_a == '0) || (len_b == '0);

  // Appends to the strings.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_valid && cmd_ready && !cmd.is_cmp) begin
      if (!cmd.second && len_a < LenMax) str_a[len_a[AW-1:0]] <= cmd.character;
      if (cmd.second && len_b < LenMax) str_b[len_b[AW-1:0]] <= cmd.character;
    end
  end

  // Registered reads of the memories for the sweep.
  always_ff @(posedge clk) begin
    b_rd  <= str_b[j[AW-1:0] - AW'(1)];
    up_rd <= row[j];
    if (state == S_ROWA) a_ch <= str_a[i[AW-1:0] - AW'(1)];
  end

  always_ff @(posedge clk) begin
    if (state == S_INIT) row[j] <= j[7:0];
    else if (state == S_ROWA) row[0] <= i[7:0];
    else if (state == S_CELL) row[j] <= best[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      len_a    <= '0;
      len_b    <= '0;
      seen     <= '0;
      ovf      <= 1'b0;
      out_full <= 1'b0;
      i        <= '0;
      j        <= '0;
    end else begin
      // The result register fills when a finished compare is posted and empties on a pop.
      if (post) out_full <= 1'b1;
      else if (pop && out_full) out_full <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            if (!cmd.is_cmp) begin
              if (!cmd.second) begin
                if (len_a < LenMax) len_a <= len_a + LW'(1);
                else ovf <= 1'b1;
              end else begin
                if (len_b < LenMax) len_b <= len_b + LW'(1);
                else ovf <= 1'b1;
                if (seen != 5'd31) seen <= seen + 5'd1;
              end
            end else if (fin_empty) begin
              dist_r <= (len_a == '0) ? len_b[7:0] : len_a[7:0];
              state  <= S_DONE;
            end else begin
              j     <= '0;
              state <= S_INIT;
            end
          end
        end
        S_INIT: begin
          if (j == len_b) begin
            i     <= LW'(1);
            state <= S_ROWA;
          end else begin
            j <= j + LW'(1);
          end
        end
        S_ROWA: begin
          // Row start: fetch a and old row[0] as diag.
          diag  <= row[0];
          left  <= i[7:0];
          j     <= LW'(1);
          state <= S_ROWB;
        end
        S_ROWB: begin
          // Wait for the registered reads at j.
          state <= S_CELL;
        end
        S_CELL: begin
          diag <= up_rd;
          left <= best[7:0];
          if (j == len_b) begin
            if (i == len_a) begin
              dist_r <= best[7:0];
              state  <= S_DONE;
            end else begin
              i     <= i + LW'(1);
              state <= S_ROWA;
            end
          end else begin
            j     <= j + LW'(1);
            state <= S_ROWB;
          end
        end
        S_DONE: begin
          // Hold the finished compare until the result register is free.
          if (post) begin
            result.distance  <= dist_r;
            result.is_match  <= !fin_empty && (dist_r <= tol);
            result.truncated <= ovf;
            len_a    <= '0;
            len_b    <= '0;
            seen     <= '0;
            ovf      <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state)) else $error("state not one-hot");
  a_len_a: assert property (@(posedge clk) disable iff (rst)
    len_a <= LenMax) else $error("first length past maximum");
  a_done_fill: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |=> out_full) else $error("result not posted");

endmodule

@@ src/edit_distance_fuzzy_match.sv @@
// Edit-distance fuzzy matcher.
// Input queue side: push an item (mode, character) while full is low.
//   Mode 0 appends a character to the input string, mode 1 to the target
//   string, mode 2 compares and clears both; mode 3 is dropped.
// Result queue side: while empty is low, the result (distance, is_match,
//   truncated) is on the ports; pop transfers it.
// Appends pass through a two-entry command queue and are taken while the back is idle.
// A compare of lengths n1 and n2 lowers empty after its transfer once the sweep
//   is done: each cost-row cell takes a wait state and a cell state, each row a
//   row-start state, and the row is first seeded with n2 + 1 entries.
// A compare with an empty string skips the sweep and goes straight to the done state.
// During a sweep the queue takes two more items and then raises full.
// A finished result that waits for pop holds the back in its done state, so
//   a stalled receiver holds off all later items behind that compare.
// Reset empties both strings and the queues and sets case_fold to 1.
// Register 0 at address 0 is case_fold.
module edit_distance_fuzzy_match #(
  parameter int unsigned MAX_LEN = edf_pkg::MaxLenDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  edf_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output edf_pkg::out_item_t out_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [0:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic          case_fold;
  logic          cmd_valid, cmd_ready;
  edf_pkg::cmd_t cmd;

  assign pready = 1'b1;
  assign prdata = (paddr == edf_pkg::REG_CASE_FOLD) ? {31'd0, case_fold} : 32'd0;

  // Configuration register write.
  always_ff @(posedge clk) begin
    if (rst) begin
      case_fold <= 1'b1;
    end else if (psel && penable && pwrite && paddr == edf_pkg::REG_CASE_FOLD) begin
      case_fold <= pwdata[0];
    end
  end

  edf_front u_front (
    .clk, .rst, .push, .full, .item(in_item),
    .cmd_valid, .cmd_ready, .cmd
  );

  edf_back #(.MAX_LEN(MAX_LEN)) u_back (
    .clk, .rst, .case_fold, .cmd_valid, .cmd_ready, .cmd,
    .empty, .pop, .result(out_item)
  );

endmodule
